[hw/rtl/ncpu_pkg.sv]
// Shared types and constants for the accumulator CPU step unit.
// Holds opcodes, item modes, status codes, micro-step codes and the control word.
// No dependencies.
package ncpu_pkg;

  // Memory depth. It must be a power of two so that the low address bits
  // give the word index.
  localparam int MEM_WORDS = 256;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  // Item modes
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_EXEC    = 2'd2;
  localparam logic [1:0] MODE_RESTART = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_RUN   = 2'd0;
  localparam logic [1:0] STAT_HALT  = 2'd1;
  localparam logic [1:0] STAT_FAULT = 2'd2;

  // Opcodes, matched on the whole byte
  localparam logic [7:0] OP_NOP = 8'h00;
  localparam logic [7:0] OP_STA = 8'h10;
  localparam logic [7:0] OP_LDA = 8'h20;
  localparam logic [7:0] OP_ADD = 8'h30;
  localparam logic [7:0] OP_SUB = 8'h31;
  localparam logic [7:0] OP_OR  = 8'h40;
  localparam logic [7:0] OP_AND = 8'h50;
  localparam logic [7:0] OP_NOT = 8'h60;
  localparam logic [7:0] OP_JMP = 8'h80;
  localparam logic [7:0] OP_JMN = 8'h90;
  localparam logic [7:0] OP_JMZ = 8'hA0;
  localparam logic [7:0] OP_HLT = 8'hF0;

  // Micro-step addresses
  localparam logic [3:0] U_WR   = 4'd0;
  localparam logic [3:0] U_RD0  = 4'd1;
  localparam logic [3:0] U_RD1  = 4'd2;
  localparam logic [3:0] U_X0   = 4'd3;
  localparam logic [3:0] U_X1   = 4'd4;
  localparam logic [3:0] U_X2   = 4'd5;
  localparam logic [3:0] U_ST   = 4'd6;
  localparam logic [3:0] U_AL   = 4'd7;
  localparam logic [3:0] U_JP   = 4'd8;
  localparam logic [3:0] U_HLT  = 4'd9;
  localparam logic [3:0] U_FLT  = 4'd10;
  localparam logic [3:0] U_RS   = 4'd11;
  localparam logic [3:0] U_END  = 4'd12;

  // Memory address sources
  localparam logic [2:0] AS_IN   = 3'd0;
  localparam logic [2:0] AS_PC   = 3'd1;
  localparam logic [2:0] AS_PC1  = 3'd2;
  localparam logic [2:0] AS_MEMQ = 3'd3;
  localparam logic [2:0] AS_OPND = 3'd4;

  // Write data sources
  localparam logic WS_DATA = 1'b0;
  localparam logic WS_ACC  = 1'b1;

  // Accumulator actions
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_ALU  = 2'd1;
  localparam logic [1:0] ACC_ZERO = 2'd2;

  // PC actions
  localparam logic [1:0] PC_HOLD   = 2'd0;
  localparam logic [1:0] PC_INC2   = 2'd1;
  localparam logic [1:0] PC_BRANCH = 2'd2;
  localparam logic [1:0] PC_ZERO   = 2'd3;

  // Sequencer jump kinds
  localparam logic [1:0] J_NEXT   = 2'd0;
  localparam logic [1:0] J_STOP   = 2'd1;
  localparam logic [1:0] J_DECODE = 2'd2;

  typedef struct packed {
    logic [2:0] addr_sel;
    logic       mem_rd;
    logic       mem_we;
    logic       wr_sel;
    logic       ir_ld;
    logic       opnd_ld;
    logic       rd_ld;
    logic [1:0] acc_op;
    logic [1:0] pc_op;
    logic       set_halt;
    logic       set_fault;
    logic       clr_marks;
    logic [1:0] jmp;
    logic [3:0] target;
    logic       done;
  } ncpu_uword_t;

  // Datapath state seen by the sequencer
  typedef struct packed {
    logic       stopped;
    logic [7:0] ir;
  } ncpu_dstat_t;

endpackage

[hw/rtl/ncpu_seq.sv]
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on ncpu_pkg.
module ncpu_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [1:0]           go_mode,
  input  ncpu_pkg::ncpu_dstat_t dstat,
  output ncpu_pkg::ncpu_uword_t ctl,
  output logic                 busy
);

  logic       busy_r, busy_nxt;
  logic [3:0] upc_r, upc_nxt;
  ncpu_pkg::ncpu_uword_t uw;

  function automatic ncpu_pkg::ncpu_uword_t rom(input logic [3:0] a);
    ncpu_pkg::ncpu_uword_t w;
    w = '0;
    case (a)
      ncpu_pkg::U_WR: begin
        w.addr_sel = ncpu_pkg::AS_IN;
        w.mem_we   = 1'b1;
        w.wr_sel   = ncpu_pkg::WS_DATA;
        w.done     = 1'b1;
      end
      ncpu_pkg::U_RD0: begin
        w.addr_sel = ncpu_pkg::AS_IN;
        w.mem_rd   = 1'b1;
        w.jmp      = ncpu_pkg::J_NEXT;
      end
      ncpu_pkg::U_RD1: begin
        w.rd_ld = 1'b1;
        w.done  = 1'b1;
      end
      ncpu_pkg::U_X0: begin
        w.addr_sel = ncpu_pkg::AS_PC;
        w.mem_rd   = 1'b1;
        w.jmp      = ncpu_pkg::J_STOP;
        w.target   = ncpu_pkg::U_END;
      end
      ncpu_pkg::U_X1: begin
        w.ir_ld    = 1'b1;
        w.addr_sel = ncpu_pkg::AS_PC1;
        w.mem_rd   = 1'b1;
        w.jmp      = ncpu_pkg::J_NEXT;
      end
      ncpu_pkg::U_X2: begin
        w.opnd_ld  = 1'b1;
        w.addr_sel = ncpu_pkg::AS_MEMQ;
        w.mem_rd   = 1'b1;
        w.jmp      = ncpu_pkg::J_DECODE;
      end
      ncpu_pkg::U_ST: begin
        w.addr_sel = ncpu_pkg::AS_OPND;
        w.mem_we   = 1'b1;
        w.wr_sel   = ncpu_pkg::WS_ACC;
        w.pc_op    = ncpu_pkg::PC_INC2;
        w.done     = 1'b1;
      end
      ncpu_pkg::U_AL: begin
        w.acc_op = ncpu_pkg::ACC_ALU;
        w.pc_op  = ncpu_pkg::PC_INC2;
        w.done   = 1'b1;
      end
      ncpu_pkg::U_JP: begin
        w.pc_op = ncpu_pkg::PC_BRANCH;
        w.done  = 1'b1;
      end
      ncpu_pkg::U_HLT: begin
        w.set_halt = 1'b1;
        w.done     = 1'b1;
      end
      ncpu_pkg::U_FLT: begin
        w.set_fault = 1'b1;
        w.done      = 1'b1;
      end
      ncpu_pkg::U_RS: begin
        w.acc_op    = ncpu_pkg::ACC_ZERO;
        w.pc_op     = ncpu_pkg::PC_ZERO;
        w.clr_marks = 1'b1;
        w.done      = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic logic [3:0] mode_entry(input logic [1:0] m);
    case (m)
      ncpu_pkg::MODE_WRITE: return ncpu_pkg::U_WR;
      ncpu_pkg::MODE_READ:  return ncpu_pkg::U_RD0;
      ncpu_pkg::MODE_EXEC:  return ncpu_pkg::U_X0;
      default:              return ncpu_pkg::U_RS;
    endcase
  endfunction

  function automatic logic [3:0] decode(input logic [7:0] op);
    case (op)
      ncpu_pkg::OP_NOP, ncpu_pkg::OP_JMP,
      ncpu_pkg::OP_JMN, ncpu_pkg::OP_JMZ: return ncpu_pkg::U_JP;
      ncpu_pkg::OP_STA:                   return ncpu_pkg::U_ST;
      ncpu_pkg::OP_LDA, ncpu_pkg::OP_ADD, ncpu_pkg::OP_SUB,
      ncpu_pkg::OP_OR,  ncpu_pkg::OP_AND, ncpu_pkg::OP_NOT: return ncpu_pkg::U_AL;
      ncpu_pkg::OP_HLT:                   return ncpu_pkg::U_HLT;
      default:                            return ncpu_pkg::U_FLT;
    endcase
  endfunction

  assign uw = rom(upc_r);

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (!busy_r) begin
      if (go) begin
        busy_nxt = 1'b1;
        upc_nxt  = mode_entry(go_mode);
      end
    end else if (uw.done) begin
      busy_nxt = 1'b0;
    end else begin
      case (uw.jmp)
        ncpu_pkg::J_STOP:   upc_nxt = dstat.stopped ? uw.target : upc_r + 4'd1;
        ncpu_pkg::J_DECODE: upc_nxt = decode(dstat.ir);
        default:            upc_nxt = upc_r + 4'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= ncpu_pkg::U_WR;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  assign ctl  = busy_r ? uw : '0;
  assign busy = busy_r;

endmodule

[hw/rtl/ncpu_dp.sv]
// Datapath: word memory with clearing pass, AC, PC, IR, operand and stop marks.
// Depends on ncpu_pkg; driven by the control word from ncpu_seq.
module ncpu_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ncpu_pkg::ncpu_uword_t ctl,
  input  logic [7:0]            item_addr,
  input  logic [7:0]            item_wdata,
  output ncpu_pkg::ncpu_dstat_t dstat,
  output logic                  clearing,
  output logic [7:0]            acc,
  output logic [7:0]            pc,
  output logic [7:0]            rdata,
  output logic                  halted,
  output logic                  fault
);

  logic [7:0] mem [ncpu_pkg::MEM_WORDS];
  logic [7:0] mem_q_r;

  logic                      clr_busy_r;
  logic [ncpu_pkg::MEM_AW-1:0] clr_cnt_r;

  logic [7:0] acc_r, acc_nxt;
  logic [7:0] pc_r, pc_nxt;
  logic [7:0] ir_r, opnd_r, rd_r;
  logic       halt_r, halt_nxt, fault_r, fault_nxt;

  logic [7:0] maddr;
  logic [7:0] wdata;
  logic [7:0] alu_y;
  logic       taken;

  always_comb begin
    case (ctl.addr_sel)
      ncpu_pkg::AS_PC:   maddr = pc_r;
      ncpu_pkg::AS_PC1:  maddr = pc_r + 8'd1;
      ncpu_pkg::AS_MEMQ: maddr = mem_q_r;
      ncpu_pkg::AS_OPND: maddr = opnd_r;
      default:           maddr = item_addr;
    endcase
  end

  assign wdata = (ctl.wr_sel == ncpu_pkg::WS_ACC) ? acc_r : item_wdata;

  // Single port: the clearing pass owns the write side until it ends
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= 8'h00;
    end else if (ctl.mem_we) begin
      mem[maddr[ncpu_pkg::MEM_AW-1:0]] <= wdata;
    end
    if (ctl.mem_rd) begin
      mem_q_r <= mem[maddr[ncpu_pkg::MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ncpu_pkg::MEM_AW'(ncpu_pkg::MEM_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    case (ir_r)
      ncpu_pkg::OP_ADD: alu_y = acc_r + mem_q_r;
      ncpu_pkg::OP_SUB: alu_y = acc_r - mem_q_r;
      ncpu_pkg::OP_OR:  alu_y = acc_r | mem_q_r;
      ncpu_pkg::OP_AND: alu_y = acc_r & mem_q_r;
      ncpu_pkg::OP_NOT: alu_y = ~acc_r;
      default:          alu_y = mem_q_r;
    endcase
  end

  // Jumps test AC as it stands when the instruction starts
  always_comb begin
    case (ir_r)
      ncpu_pkg::OP_JMP: taken = 1'b1;
      ncpu_pkg::OP_JMN: taken = acc_r[7];
      ncpu_pkg::OP_JMZ: taken = (acc_r == 8'h00);
      default:          taken = 1'b0;
    endcase
  end

  always_comb begin
    case (ctl.acc_op)
      ncpu_pkg::ACC_ALU:  acc_nxt = alu_y;
      ncpu_pkg::ACC_ZERO: acc_nxt = 8'h00;
      default:            acc_nxt = acc_r;
    endcase
    case (ctl.pc_op)
      ncpu_pkg::PC_INC2:   pc_nxt = pc_r + 8'd2;
      ncpu_pkg::PC_BRANCH: pc_nxt = taken ? opnd_r : pc_r + 8'd2;
      ncpu_pkg::PC_ZERO:   pc_nxt = 8'h00;
      default:             pc_nxt = pc_r;
    endcase
    halt_nxt  = (halt_r & ~ctl.clr_marks) | ctl.set_halt;
    fault_nxt = (fault_r & ~ctl.clr_marks) | ctl.set_fault;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 8'h00;
      pc_r    <= 8'h00;
      halt_r  <= 1'b0;
      fault_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ir_ld)   ir_r   <= mem_q_r;
    if (ctl.opnd_ld) opnd_r <= mem_q_r;
    if (ctl.rd_ld)   rd_r   <= mem_q_r;
  end

  assign dstat.stopped = halt_r | fault_r;
  assign dstat.ir      = ir_r;
  assign clearing      = clr_busy_r;
  assign acc           = acc_r;
  assign pc            = pc_r;
  assign rdata         = rd_r;
  assign halted        = halt_r;
  assign fault         = fault_r;

endmodule

[hw/rtl/accumulator_cpu_step_unit.sv]
// Top level of the 8-bit accumulator CPU step unit.
// Instantiates ncpu_seq and ncpu_dp; uses ncpu_pkg.

// Each input beat is one operation on a small accumulator machine with one
// 256-word memory: write a word, read a word, execute one instruction, or
// restart (AC, PC and the stop marks cleared, memory kept). Every beat gives
// one result beat with AC, PC, flags and status after the operation. Work is
// done by a microprogram on a one-port memory with a registered read, so the
// number of micro-steps sets the rate: write 1, read 2, restart 1, execute 4
// (opcode fetch, operand fetch, data read, retire with any store write; 2
// when the machine is stopped). The result then waits as pending until the
// output register can take it. The next beat is taken while a result still
// waits in the output register. After reset a clearing pass zeroes the
// memory, one word a cycle; in_ready stays low until it ends.
module accumulator_cpu_step_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_address,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic [7:0] out_accumulator,
  output logic [7:0] out_program_counter,
  output logic       out_zero_flag,
  output logic       out_negative_flag,
  output logic [1:0] out_status
);

  ncpu_pkg::ncpu_uword_t ctl;
  ncpu_pkg::ncpu_dstat_t dstat;

  logic       busy, clearing;
  logic [7:0] acc, pc, rdata;
  logic       halted, fault;

  logic       in_fire, slot_free, load_out;
  logic [1:0] mode_r;
  logic [7:0] addr_r, wdata_r;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_rd_r, out_acc_r, out_pc_r;
  logic [1:0] out_stat_r;

  // A result is pending once the microprogram retires; it moves to the
  // output register as soon as that register is empty or being drained.
  assign slot_free = ~out_valid_r | out_ready;
  assign load_out  = pend_r & slot_free;
  assign in_ready  = ~busy & ~clearing & (~pend_r | slot_free);
  assign in_fire   = in_valid & in_ready;

  // Hold the item fields for the whole microprogram
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r  <= in_mode;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
    end
  end

  ncpu_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (in_fire),
    .go_mode (in_mode),
    .dstat   (dstat),
    .ctl     (ctl),
    .busy    (busy)
  );

  ncpu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .item_addr  (addr_r),
    .item_wdata (wdata_r),
    .dstat      (dstat),
    .clearing   (clearing),
    .acc        (acc),
    .pc         (pc),
    .rdata      (rdata),
    .halted     (halted),
    .fault      (fault)
  );

  always_comb begin
    pend_nxt = pend_r;
    if (load_out) pend_nxt = 1'b0;
    if (ctl.done) pend_nxt = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load_out)                 out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Snapshot the architectural state; read data shows only for reads
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rd_r   <= (mode_r == ncpu_pkg::MODE_READ) ? rdata : 8'h00;
      out_acc_r  <= acc;
      out_pc_r   <= pc;
      out_stat_r <= fault  ? ncpu_pkg::STAT_FAULT :
                    halted ? ncpu_pkg::STAT_HALT  : ncpu_pkg::STAT_RUN;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_rd_r;
  assign out_accumulator     = out_acc_r;
  assign out_program_counter = out_pc_r;
  assign out_zero_flag       = (out_acc_r == 8'h00);
  assign out_negative_flag   = out_acc_r[7];
  assign out_status          = out_stat_r;

  // An accepted beat starts the microprogram
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy)
    else $error("accepted beat did not start the sequencer");

  // A retiring step always leaves a pending result
  a_retire: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |=> pend_r)
    else $error("retired item left no pending result");

  // A pending result is not dropped while the output register is blocked
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_valid_r && !out_ready) |=> pend_r)
    else $error("pending result lost under back-pressure");

  // The sequencer never runs during the clearing pass
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !busy)
    else $error("sequencer active during memory clear");

endmodule

[verif/accumulator_cpu_step_unit_tb.sv]
// Self-checking testbench for the accumulator CPU step unit: random and directed beats
// are checked against a cycle-free model of the machine. Depends on ncpu_pkg and
// accumulator_cpu_step_unit.
module accumulator_cpu_step_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ncpu_pkg::*;

  // Give up after this many cycles; a correct run needs a small fraction of it.
  localparam int CYCLE_LIMIT = 200000;
  // Stop adding random beats once the stimulus queue holds this many.
  localparam int TARGET_BEATS = 925;
  // Cycles without any idling on either side.
  localparam int QUIET_FROM = 2500;
  localparam int QUIET_TO = 3500;
  // Long receiver hold-off: when it starts and how long it lasts.
  localparam int HOLD_AFTER_BEATS = 300;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] address;
    logic [7:0] write_data;
  } cpu_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] accumulator;
    logic [7:0] program_counter;
    logic       zero_flag;
    logic       negative_flag;
    logic [1:0] status;
  } cpu_view_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_mode = MODE_READ;
  logic [7:0] in_address = 8'h00;
  logic [7:0] in_write_data = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic [7:0] out_accumulator;
  logic [7:0] out_program_counter;
  logic       out_zero_flag;
  logic       out_negative_flag;
  logic [1:0] out_status;

  accumulator_cpu_step_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_data       (out_read_data),
    .out_accumulator     (out_accumulator),
    .out_program_counter (out_program_counter),
    .out_zero_flag       (out_zero_flag),
    .out_negative_flag   (out_negative_flag),
    .out_status          (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Machine image kept by the testbench: memory, AC, PC and the two stop marks.
  logic [7:0] mem_img [MEM_WORDS];
  logic [7:0] acc_img;
  logic [7:0] pc_img;
  logic       halt_img;
  logic       fault_img;

  cpu_beat_t  stim_q [$];
  cpu_view_t  pending_views [$];
  int         total_beats = 0;
  int         accepted_beats = 0;
  int         fail_count = 0;
  int         cycle_cnt = 0;
  logic       in_taken = 1'b0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  logic       quiet;

  assign quiet = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

  // Apply one accepted beat to the machine image and return the result it must produce.
  function automatic cpu_view_t predict_cpu_step(cpu_beat_t b);
    cpu_view_t  v;
    logic [7:0] opc;
    logic [7:0] opnd;
    logic [7:0] pc_next;
    logic       was_neg;
    logic       was_zero;
    logic       retire;
    v = '0;
    case (b.mode)
      MODE_WRITE: mem_img[b.address % MEM_WORDS] = b.write_data;
      MODE_READ: v.read_data = mem_img[b.address % MEM_WORDS];
      MODE_EXEC: begin
        if (!halt_img && !fault_img) begin
          opc = mem_img[pc_img % MEM_WORDS];
          pc_next = pc_img + 8'd1;
          opnd = mem_img[pc_next % MEM_WORDS];
          pc_next = pc_img + 8'd2;
          // Conditional jumps look at AC as it stands before the instruction.
          was_neg = acc_img[7];
          was_zero = (acc_img == 8'h00);
          retire = 1'b1;
          case (opc)
            OP_NOP: ;
            OP_STA: mem_img[opnd % MEM_WORDS] = acc_img;
            OP_LDA: acc_img = mem_img[opnd % MEM_WORDS];
            OP_ADD: acc_img = acc_img + mem_img[opnd % MEM_WORDS];
            OP_SUB: acc_img = acc_img - mem_img[opnd % MEM_WORDS];
            OP_OR: acc_img = acc_img | mem_img[opnd % MEM_WORDS];
            OP_AND: acc_img = acc_img & mem_img[opnd % MEM_WORDS];
            OP_NOT: acc_img = ~acc_img;
            OP_JMP: pc_next = opnd;
            OP_JMN: if (was_neg) pc_next = opnd;
            OP_JMZ: if (was_zero) pc_next = opnd;
            OP_HLT: begin
              // PC stays on the HLT word.
              halt_img = 1'b1;
              retire = 1'b0;
            end
            default: begin
              fault_img = 1'b1;
              retire = 1'b0;
            end
          endcase
          if (retire) pc_img = pc_next;
        end
      end
      default: begin
        // Restart keeps memory.
        acc_img = 8'h00;
        pc_img = 8'h00;
        halt_img = 1'b0;
        fault_img = 1'b0;
      end
    endcase
    v.accumulator = acc_img;
    v.program_counter = pc_img;
    v.zero_flag = (acc_img == 8'h00);
    v.negative_flag = acc_img[7];
    v.status = fault_img ? STAT_FAULT : (halt_img ? STAT_HALT : STAT_RUN);
    return v;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, int got_v, int want_v);
    if (got_v != want_v)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got_v, want_v));
  endtask

  task automatic push_beat(logic [1:0] m, logic [7:0] a, logic [7:0] d);
    cpu_beat_t b;
    b.mode = m;
    b.address = a;
    b.write_data = d;
    stim_q.push_back(b);
  endtask

  // Favor values that drive the flags and the wrap of ADD and SUB.
  function automatic logic [7:0] pick_data();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'h80;
      2: return 8'hFF;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(13))
      0: return OP_NOP;
      1: return OP_STA;
      2: return OP_LDA;
      3: return OP_ADD;
      4: return OP_SUB;
      5: return OP_OR;
      6: return OP_AND;
      7: return OP_NOT;
      8: return OP_JMP;
      9: return OP_JMN;
      10: return OP_JMZ;
      11: return OP_HLT;
      12: return 8'($urandom_range(255));
      default: return OP_ADD;
    endcase
  endfunction

  // Load a short random program, restart, and step it, with reads mixed in.
  task automatic queue_program();
    int         n_instr;
    int         n_exec;
    logic [7:0] base;
    logic [7:0] at;
    logic [7:0] opc;
    logic [7:0] opnd;
    n_instr = $urandom_range(1, 8);
    // Place some programs high in memory so that PC wraps past 255.
    base = ($urandom_range(3) == 0) ? 8'($urandom_range(8, 127) * 2) : 8'h00;
    repeat ($urandom_range(1, 4))
      push_beat(MODE_WRITE, 8'hF0 + 8'($urandom_range(15)), pick_data());
    if (base != 8'h00) begin
      push_beat(MODE_WRITE, 8'h00, OP_JMP);
      push_beat(MODE_WRITE, 8'h01, base);
    end
    for (int i = 0; i < n_instr; i++) begin
      at = base + 8'(2 * i);
      opc = pick_opcode();
      if (i == n_instr - 1 && $urandom_range(1) == 1) opc = OP_HLT;
      if (opc == OP_JMP || opc == OP_JMN || opc == OP_JMZ)
        opnd = ($urandom_range(4) != 0) ? base + 8'(2 * $urandom_range(n_instr - 1))
                                        : 8'($urandom_range(255));
      else
        opnd = ($urandom_range(4) != 0) ? 8'hF0 + 8'($urandom_range(15))
                                        : 8'($urandom_range(255));
      push_beat(MODE_WRITE, at, opc);
      push_beat(MODE_WRITE, at + 8'd1, opnd);
    end
    push_beat(MODE_RESTART, 8'($urandom_range(255)), 8'($urandom_range(255)));
    n_exec = 2 * n_instr + $urandom_range(1, 4);
    repeat (n_exec) begin
      push_beat(MODE_EXEC, 8'($urandom_range(255)), 8'($urandom_range(255)));
      if ($urandom_range(5) == 0)
        push_beat(MODE_READ, 8'hF0 + 8'($urandom_range(15)), 8'($urandom_range(255)));
    end
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 6))
      push_beat(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // Driver: present the next beat at the falling edge, hold it until it is taken.
  always @(negedge clk) begin : drive_proc
    cpu_beat_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (stim_q.size() > 0 && (quiet || $urandom_range(99) >= 21)) begin
        nxt = stim_q.pop_front();
        in_valid <= 1'b1;
        in_mode <= nxt.mode;
        in_address <= nxt.address;
        in_write_data <= nxt.write_data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off that fills the block.
  always @(negedge clk) begin : sink_proc
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted_beats >= HOLD_AFTER_BEATS) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 21);
    end
  end

  // Monitor: check result beats against the oldest expectation, then predict
  // the beat accepted at this edge. A result never leaves in its own accept cycle.
  always @(posedge clk) begin : monitor_proc
    cpu_view_t got;
    cpu_view_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      got.read_data = out_read_data;
      got.accumulator = out_accumulator;
      got.program_counter = out_program_counter;
      got.zero_flag = out_zero_flag;
      got.negative_flag = out_negative_flag;
      got.status = out_status;
      if (pending_views.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected, acc 0x%0h pc 0x%0h",
                                  got.accumulator, got.program_counter));
      end else begin
        want = pending_views.pop_front();
        check_field("read_data", got.read_data, want.read_data);
        check_field("accumulator", got.accumulator, want.accumulator);
        check_field("program_counter", got.program_counter, want.program_counter);
        check_field("zero_flag", got.zero_flag, want.zero_flag);
        check_field("negative_flag", got.negative_flag, want.negative_flag);
        check_field("status", got.status, want.status);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      pending_views.push_back(predict_cpu_step({in_mode, in_address, in_write_data}));
      accepted_beats <= accepted_beats + 1;
    end
  end

  // Watchdog: count cycles and abort a run that hangs.
  always @(posedge clk) begin : watchdog_proc
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MEM_WORDS; i++) mem_img[i] = 8'h00;
    acc_img = 8'h00;
    pc_img = 8'h00;
    halt_img = 1'b0;
    fault_img = 1'b0;

    // Directed: memory is zero after reset, top address with full data.
    push_beat(MODE_READ, 8'h00, 8'hFF);
    push_beat(MODE_READ, 8'hFF, 8'h00);
    // NOT at 0, JMP to FE at 2, JMN at FE whose operand sits in word FF.
    push_beat(MODE_WRITE, 8'h00, OP_NOT);
    push_beat(MODE_WRITE, 8'h02, OP_JMP);
    push_beat(MODE_WRITE, 8'h03, 8'hFE);
    push_beat(MODE_WRITE, 8'hFE, OP_JMN);
    push_beat(MODE_WRITE, 8'hFF, 8'h04);
    push_beat(MODE_EXEC, 8'h00, 8'h00);
    push_beat(MODE_EXEC, 8'h00, 8'h00);
    // JMN taken on a negative AC.
    push_beat(MODE_EXEC, 8'h00, 8'h00);
    // HLT, then steps are ignored while memory access still works.
    push_beat(MODE_WRITE, 8'h04, OP_HLT);
    push_beat(MODE_EXEC, 8'h00, 8'h00);
    push_beat(MODE_EXEC, 8'hFF, 8'hFF);
    push_beat(MODE_WRITE, 8'h80, 8'hFF);
    push_beat(MODE_READ, 8'h80, 8'h00);
    push_beat(MODE_RESTART, 8'h00, 8'h00);
    push_beat(MODE_EXEC, 8'h00, 8'h00);
    push_beat(MODE_EXEC, 8'h00, 8'h00);
    // JMZ not taken at FE: PC wraps to 0.
    push_beat(MODE_WRITE, 8'hFE, OP_JMZ);
    push_beat(MODE_EXEC, 8'h00, 8'h00);
    // Illegal opcode faults, then steps are ignored until restart.
    push_beat(MODE_WRITE, 8'h00, 8'hFF);
    push_beat(MODE_EXEC, 8'h00, 8'h00);
    push_beat(MODE_EXEC, 8'h00, 8'h00);
    push_beat(MODE_RESTART, 8'hFF, 8'hFF);
    push_beat(MODE_READ, 8'hFE, 8'h00);

    // Random: mostly well-formed programs, the rest free-form beats.
    while (stim_q.size() < TARGET_BEATS) begin
      if ($urandom_range(99) < 75) queue_program();
      else queue_noise();
    end
    total_beats = stim_q.size();

    // Hold reset, then release it off the sampling edge.
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every beat taken and every result seen, then let the pipe settle.
    while (accepted_beats != total_beats || pending_views.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ncpu_pkg.sv
hw/rtl/ncpu_seq.sv
hw/rtl/ncpu_dp.sv
hw/rtl/accumulator_cpu_step_unit.sv
verif/accumulator_cpu_step_unit_tb.sv
